FILE: rtl/core/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants of the classifier statistics counter: request
// and result payloads, operation codes and default sizes.
// ----------------------------------------------------------------------------
package csc_pkg;

    // fixed field widths of the request and result payloads
    localparam int CLASS_W    = 4;
    localparam int RULE_IDX_W = 8;
    localparam int OUT_W      = 32;
    localparam int ALIVE_W    = 9;
    localparam int ALIVE_CAP  = 511;

    // default sizes handed to the top level
    localparam int DEF_MAX_CLASSES = 16;
    localparam int DEF_MAX_RULES   = 256;
    localparam int DEF_COUNT_BITS  = 32;

    // operation codes
    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    // one request
    typedef struct packed {
        op_t                   operation;
        logic [CLASS_W-1:0]    real_class;
        logic [CLASS_W-1:0]    predicted_class;
        logic                  rule_fired;
        logic [RULE_IDX_W-1:0] rule_index;
    } req_t;

    // one result
    typedef struct packed {
        logic [OUT_W-1:0]   total_seen;
        logic [OUT_W-1:0]   total_correct;
        logic [OUT_W-1:0]   total_wrong;
        logic [OUT_W-1:0]   total_unclassified;
        logic [ALIVE_W-1:0] alive_rules;
        logic [OUT_W-1:0]   cell_count;
        logic [OUT_W-1:0]   class_correct;
        logic [OUT_W-1:0]   class_wrong;
        logic [OUT_W-1:0]   class_unclassified;
        logic [OUT_W-1:0]   rule_activations;
        logic [OUT_W-1:0]   rule_correct;
        logic [OUT_W-1:0]   rule_wrong;
    } rsp_t;

endpackage

FILE: rtl/core/csc_item_if.sv
// ----------------------------------------------------------------------------
// csc_item_if
// Request channel: valid/ready handshake carrying one record or read request.
// ----------------------------------------------------------------------------
interface csc_item_if;
    logic          valid;
    logic          ready;
    csc_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/csc_result_if.sv
// ----------------------------------------------------------------------------
// csc_result_if
// Result channel: valid/ready handshake carrying one counter snapshot.
// ----------------------------------------------------------------------------
interface csc_result_if;
    logic          valid;
    logic          ready;
    csc_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/csc_ram.sv
// ----------------------------------------------------------------------------
// csc_ram
// Single write port, single read port counter store with registered read
// data. A write to the address being read in the same cycle is forwarded,
// so the read returns the freshly written value.
// ----------------------------------------------------------------------------
module csc_ram #(
    parameter  int DEPTH = 16,
    parameter  int WIDTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port with write-first forwarding
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/classifier_statistics_counter.sv
// ----------------------------------------------------------------------------
// classifier_statistics_counter
// Confusion matrix and per-class / per-rule hit counters for classifier
// evaluation, with a counter snapshot returned for every request.
// ----------------------------------------------------------------------------
// usage
//   item   : requests in; operation selects record (update counters) or read.
//            real_class/predicted_class address the confusion cell, real_class
//            the class counters, rule_index the rule counters.
//   result : one snapshot per request, showing counters after the update.
// timing
//   a request moves from the stage 1 register to the output register as
//   stage 1 advances. One request per cycle is sustained while results are
//   taken; the stores are read at acceptance and written back as stage 1
//   advances, with same-address writes forwarded into the read, so back-to-back hits on one counter are exact.
// reset
//   all counters are zero after reset. The stores are cleared by a pass over
//   max(MAX_CLASSES*MAX_CLASSES, MAX_RULES) addresses (256 at default sizes)
//   during which item.ready stays low.
// stall
//   a stalled result holds in the output register; a filled stage 1 behind
//   it holds too and item.ready drops until the result is taken.
// counters saturate at 2**COUNT_BITS-1; outputs show their low 32 bits.
// ----------------------------------------------------------------------------
module classifier_statistics_counter #(
    parameter int MAX_CLASSES = csc_pkg::DEF_MAX_CLASSES,
    parameter int MAX_RULES   = csc_pkg::DEF_MAX_RULES,
    parameter int COUNT_BITS  = csc_pkg::DEF_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    csc_item_if.sink            item,
    csc_result_if.source        result
);

    localparam int CB          = COUNT_BITS;
    localparam int CLS_AW      = $clog2(MAX_CLASSES);
    localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;
    localparam int CELL_AW     = $clog2(CELLS);
    localparam int RULE_AW     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CLR_DEPTH   = (CELLS > MAX_RULES) ? CELLS : MAX_RULES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam int ALIVE_LIMIT = (MAX_RULES < csc_pkg::ALIVE_CAP) ? MAX_RULES
                                                                   : csc_pkg::ALIVE_CAP;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic class_ok(input logic [csc_pkg::CLASS_W-1:0] c);
        class_ok = (32'(c) < 32'(MAX_CLASSES));
    endfunction

    function automatic logic rule_ok(input logic [csc_pkg::RULE_IDX_W-1:0] r);
        rule_ok = (32'(r) < 32'(MAX_RULES));
    endfunction

    function automatic logic [CLS_AW-1:0] class_addr(
        input logic [csc_pkg::CLASS_W-1:0] c);
        class_addr = CLS_AW'(c);
    endfunction

    function automatic logic [RULE_AW-1:0] rule_addr(
        input logic [csc_pkg::RULE_IDX_W-1:0] r);
        rule_addr = RULE_AW'(r);
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input csc_pkg::req_t q);
        cell_addr = CELL_AW'(class_addr(q.real_class)) * CELL_AW'(MAX_CLASSES)
                  + CELL_AW'(class_addr(q.predicted_class));
    endfunction

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic               clr_active_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic               s1_valid_reg;
    csc_pkg::req_t      s1_item_reg;
    logic               out_valid_reg;
    csc_pkg::rsp_t      out_data_reg;
    logic               s1_adv;
    logic               accept;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept     = item.valid && item.ready;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (32'(clr_cnt_reg) == CLR_DEPTH - 1)
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // stage 1 request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item.data;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 update logic
    // ------------------------------------------------------------------
    logic [CB-1:0]      cell_rd;
    logic [3*CB-1:0]    class_rd;
    logic [3*CB-1:0]    rule_rd;

    logic               rec, fired, hit, rc_ok, pc_ok, ri_ok;
    logic               upd_rule, upd_cell, upd_cls;
    logic [CB-1:0]      act_old, rcor_old, rwr_old;
    logic [CB-1:0]      act_new, rcor_new, rwr_new;
    logic [CB-1:0]      cell_new;
    logic [CB-1:0]      ccor_old, cwr_old, cun_old;
    logic [CB-1:0]      ccor_new, cwr_new, cun_new;

    logic [CB-1:0]      seen_reg, correct_reg, wrong_reg, uncl_reg;
    logic [CB-1:0]      seen_next, correct_next, wrong_next, uncl_next;
    logic [csc_pkg::ALIVE_W-1:0] alive_reg, alive_next;

    assign rec   = (s1_item_reg.operation == csc_pkg::OP_RECORD);
    assign fired = s1_item_reg.rule_fired;
    assign hit   = (s1_item_reg.real_class == s1_item_reg.predicted_class);
    assign rc_ok = class_ok(s1_item_reg.real_class);
    assign pc_ok = class_ok(s1_item_reg.predicted_class);
    assign ri_ok = rule_ok(s1_item_reg.rule_index);

    assign upd_rule = rec && fired && ri_ok;
    assign upd_cell = rec && fired && rc_ok && pc_ok;
    assign upd_cls  = rec && rc_ok;

    assign act_old  = rule_rd[3*CB-1:2*CB];
    assign rcor_old = rule_rd[2*CB-1:CB];
    assign rwr_old  = rule_rd[CB-1:0];
    assign ccor_old = class_rd[3*CB-1:2*CB];
    assign cwr_old  = class_rd[2*CB-1:CB];
    assign cun_old  = class_rd[CB-1:0];

    // per-entry counters
    always_comb
    begin
        act_new  = upd_rule ? sat_inc(act_old) : act_old;
        rcor_new = (upd_rule && hit) ? sat_inc(rcor_old) : rcor_old;
        rwr_new  = (upd_rule && !hit) ? sat_inc(rwr_old) : rwr_old;
        cell_new = upd_cell ? sat_inc(cell_rd) : cell_rd;
        ccor_new = (upd_cls && fired && hit) ? sat_inc(ccor_old) : ccor_old;
        cwr_new  = (upd_cls && fired && !hit) ? sat_inc(cwr_old) : cwr_old;
        cun_new  = (upd_cls && !fired) ? sat_inc(cun_old) : cun_old;
    end

    // global counters
    always_comb
    begin
        seen_next    = rec ? sat_inc(seen_reg) : seen_reg;
        correct_next = (rec && fired && hit) ? sat_inc(correct_reg) : correct_reg;
        wrong_next   = (rec && fired && !hit) ? sat_inc(wrong_reg) : wrong_reg;
        uncl_next    = (rec && !fired) ? sat_inc(uncl_reg) : uncl_reg;
        alive_next   = alive_reg;
        if (upd_rule && (act_old == '0)
            && (alive_reg < csc_pkg::ALIVE_W'(ALIVE_LIMIT)))
        begin
            alive_next = alive_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            correct_reg <= '0;
            wrong_reg   <= '0;
            uncl_reg    <= '0;
            alive_reg   <= '0;
        end
        else if (s1_adv)
        begin
            seen_reg    <= seen_next;
            correct_reg <= correct_next;
            wrong_reg   <= wrong_next;
            uncl_reg    <= uncl_next;
            alive_reg   <= alive_next;
        end
    end

    // ------------------------------------------------------------------
    // counter stores: write-back from stage 1, or zero during clearing
    // ------------------------------------------------------------------
    logic               cell_we, class_we, rule_we;
    logic [CELL_AW-1:0] cell_wa;
    logic [CLS_AW-1:0]  class_wa;
    logic [RULE_AW-1:0] rule_wa;
    logic [CB-1:0]      cell_wd;
    logic [3*CB-1:0]    class_wd, rule_wd;

    always_comb
    begin
        if (clr_active_reg)
        begin
            cell_we  = (32'(clr_cnt_reg) < CELLS);
            class_we = (32'(clr_cnt_reg) < MAX_CLASSES);
            rule_we  = (32'(clr_cnt_reg) < MAX_RULES);
            cell_wa  = clr_cnt_reg[CELL_AW-1:0];
            class_wa = clr_cnt_reg[CLS_AW-1:0];
            rule_wa  = clr_cnt_reg[RULE_AW-1:0];
            cell_wd  = '0;
            class_wd = '0;
            rule_wd  = '0;
        end
        else
        begin
            cell_we  = s1_adv && upd_cell;
            class_we = s1_adv && upd_cls;
            rule_we  = s1_adv && upd_rule;
            cell_wa  = cell_addr(s1_item_reg);
            class_wa = class_addr(s1_item_reg.real_class);
            rule_wa  = rule_addr(s1_item_reg.rule_index);
            cell_wd  = cell_new;
            class_wd = {ccor_new, cwr_new, cun_new};
            rule_wd  = {act_new, rcor_new, rwr_new};
        end
    end

    csc_ram #(
        .DEPTH (CELLS),
        .WIDTH (CB)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (cell_we),
        .wr_addr (cell_wa),
        .wr_data (cell_wd),
        .rd_en   (accept),
        .rd_addr (cell_addr(item.data)),
        .rd_data (cell_rd)
    );

    csc_ram #(
        .DEPTH (MAX_CLASSES),
        .WIDTH (3 * CB)
    ) u_class_ram (
        .clk     (clk),
        .wr_en   (class_we),
        .wr_addr (class_wa),
        .wr_data (class_wd),
        .rd_en   (accept),
        .rd_addr (class_addr(item.data.real_class)),
        .rd_data (class_rd)
    );

    csc_ram #(
        .DEPTH (MAX_RULES),
        .WIDTH (3 * CB)
    ) u_rule_ram (
        .clk     (clk),
        .wr_en   (rule_we),
        .wr_addr (rule_wa),
        .wr_data (rule_wd),
        .rd_en   (accept),
        .rd_addr (rule_addr(item.data.rule_index)),
        .rd_data (rule_rd)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    csc_pkg::rsp_t rsp_next;

    always_comb
    begin
        rsp_next.total_seen         = csc_pkg::OUT_W'(seen_next);
        rsp_next.total_correct      = csc_pkg::OUT_W'(correct_next);
        rsp_next.total_wrong        = csc_pkg::OUT_W'(wrong_next);
        rsp_next.total_unclassified = csc_pkg::OUT_W'(uncl_next);
        rsp_next.alive_rules        = alive_next;
        rsp_next.cell_count         = (rc_ok && pc_ok) ? csc_pkg::OUT_W'(cell_new) : '0;
        rsp_next.class_correct      = rc_ok ? csc_pkg::OUT_W'(ccor_new) : '0;
        rsp_next.class_wrong        = rc_ok ? csc_pkg::OUT_W'(cwr_new) : '0;
        rsp_next.class_unclassified = rc_ok ? csc_pkg::OUT_W'(cun_new) : '0;
        rsp_next.rule_activations   = ri_ok ? csc_pkg::OUT_W'(act_new) : '0;
        rsp_next.rule_correct       = ri_ok ? csc_pkg::OUT_W'(rcor_new) : '0;
        rsp_next.rule_wrong         = ri_ok ? csc_pkg::OUT_W'(rwr_new) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no request taken while the stores are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk)
        clr_active_reg |-> !item.ready)
        else $error("request accepted during clearing pass");

    // alive rule count stays within its limit
    a_alive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        alive_reg <= csc_pkg::ALIVE_W'(ALIVE_LIMIT))
        else $error("alive rule count above limit");

    // a finished request always lands in the output register
    a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("stage 1 advanced without loading result");

    // the seen count moves only when a record leaves stage 1
    a_seen_only_on_record: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_adv && rec) |=> $stable(seen_reg))
        else $error("seen count changed without a record");

endmodule
